/* src/kaemt_pkg.sv */
package kaemt_pkg;

    // Operation codes carried on the op field
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SCALE  = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    // 64-bit signed limits
    localparam logic [63:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] VAL_MIN = 64'h8000_0000_0000_0000;

    // One table entry as held in the store
    typedef struct packed {
        logic [31:0] key;
        logic [63:0] value;
    } entry_t;

    // Signed add that clamps at the 64-bit limits
    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if ((a[63] == b[63]) && (s[63] != a[63]))
        begin
            return a[63] ? VAL_MIN : VAL_MAX;
        end
        return s;
    endfunction

endpackage

/* src/keyed_accumulator_evict_min_table.sv */
// Keyed accumulator table with minimum eviction.
// Input channel: in_valid / in_stall with op, key, amount, factor. A request is
// taken when in_valid is high and in_stall is low; in_stall is high while a
// request is being worked on.
// Output channel: out_valid / out_stall with top_valid, top_key, entry_count,
// evicted; one result per request, held stable while out_stall is high.
// Each request scans the occupied entries of the table memory (one entry a
// cycle through its single read port) for a key match, the minimum and the
// last entry, writes back at most one entry, then scans the updated table for
// the maximum. On an empty table the match scan is skipped. A scale request
// that hits also runs the shared 32x16 multiplier before its write-back.
// The next request can be taken once the current result has moved into the
// output register.
// A result waiting in the output register does not block acceptance of the
// next request; the block only waits at the end of that request if the
// earlier result is still stalled.
// Reset clears the entry count and control state; memory contents are not
// cleared since only occupied slots are ever read.
module keyed_accumulator_evict_min_table
    import kaemt_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [31:0] key,
    input  logic [63:0] amount,
    input  logic [15:0] factor,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        top_valid,
    output logic [31:0] top_key,
    output logic [4:0]  entry_count,
    output logic        evicted
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_MOD  = 6'b000100,
        S_MUL  = 6'b001000,
        S_TOP  = 6'b010000,
        S_PUSH = 6'b100000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] addr_reg, addr_next;
    logic          rd_vld_reg;
    logic [IW-1:0] rd_idx_reg;

    logic [1:0]    op_reg;
    logic [31:0]   key_reg;
    logic [63:0]   amount_reg;
    logic [15:0]   factor_reg;

    logic          found_reg;
    logic [IW-1:0] match_idx_reg;
    logic [63:0]   match_val_reg;
    logic [IW-1:0] min_idx_reg;
    logic [63:0]   min_val_reg;
    logic [31:0]   last_key_reg;
    logic [63:0]   last_val_reg;
    logic [63:0]   max_val_reg;
    logic [31:0]   max_key_reg;
    logic          ev_reg;

    logic          out_valid_reg;
    logic          top_valid_reg;
    logic [31:0]   top_key_reg;
    logic [4:0]    entry_count_reg;
    logic          evicted_reg;

    logic          accept;
    logic          issue;
    logic          last_hit;
    logic          out_free;
    logic          ev_set;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    entry_t        wr_data;
    entry_t        rd_data;
    logic          scl_start;
    logic          scl_done;
    logic [63:0]   scl_result;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // Scan read issue, shared by the match scan and the maximum scan
    assign issue    = ((state_reg == S_SCAN) || (state_reg == S_TOP)) && (addr_reg < count_reg);
    assign last_hit = rd_vld_reg && (CW'(rd_idx_reg) == (count_reg - CW'(1)));

    kaemt_store #(
        .DEPTH (CAPACITY),
        .AW    (IW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (issue),
        .rd_addr (addr_reg[IW-1:0]),
        .rd_data (rd_data)
    );

    kaemt_scale u_scale (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (scl_start),
        .value  (match_val_reg),
        .factor (factor_reg),
        .done   (scl_done),
        .result (scl_result)
    );

    // Sequencer and write-back decision
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        addr_next  = addr_reg;
        wr_en      = 1'b0;
        wr_addr    = match_idx_reg;
        wr_data    = '{key: key_reg, value: amount_reg};
        ev_set     = 1'b0;
        scl_start  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    addr_next  = '0;
                    state_next = (count_reg == '0) ? S_MOD : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    addr_next = addr_reg + CW'(1);
                end
                if (last_hit)
                begin
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                addr_next  = '0;
                state_next = S_TOP;
                case (op_reg)
                    OP_ADD:
                    begin
                        wr_en = 1'b1;
                        if (found_reg)
                        begin
                            wr_data.value = sat_add(match_val_reg, amount_reg);
                        end
                        else if (count_reg < CW'(CAPACITY))
                        begin
                            wr_addr    = count_reg[IW-1:0];
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            wr_addr = min_idx_reg;
                            ev_set  = 1'b1;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (found_reg)
                        begin
                            wr_en      = 1'b1;
                            wr_data    = '{key: last_key_reg, value: last_val_reg};
                            count_next = count_reg - CW'(1);
                        end
                    end
                    OP_SCALE:
                    begin
                        if (found_reg)
                        begin
                            scl_start  = 1'b1;
                            state_next = S_MUL;
                        end
                    end
                    default:
                    begin
                        // query: table unchanged
                    end
                endcase
            end
            S_MUL:
            begin
                if (scl_done)
                begin
                    wr_en         = 1'b1;
                    wr_data.value = scl_result;
                    state_next    = S_TOP;
                end
            end
            S_TOP:
            begin
                if (issue)
                begin
                    addr_next = addr_reg + CW'(1);
                end
                if ((count_reg == '0) || last_hit)
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            addr_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            ev_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            addr_reg   <= addr_next;
            rd_vld_reg <= issue;
            if (accept)
            begin
                found_reg <= 1'b0;
                ev_reg    <= 1'b0;
            end
            else if ((state_reg == S_SCAN) && rd_vld_reg && !found_reg
                     && (rd_data.key == key_reg))
            begin
                found_reg <= 1'b1;
            end
            else if (state_reg == S_MOD)
            begin
                ev_reg <= ev_set;
            end
            if ((state_reg == S_PUSH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture and scan tracking
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= addr_reg[IW-1:0];
        if (accept)
        begin
            op_reg     <= op;
            key_reg    <= key;
            amount_reg <= amount;
            factor_reg <= factor;
        end
        // match, minimum and last entry
        if ((state_reg == S_SCAN) && rd_vld_reg)
        begin
            if (!found_reg && (rd_data.key == key_reg))
            begin
                match_idx_reg <= rd_idx_reg;
                match_val_reg <= rd_data.value;
            end
            if ((rd_idx_reg == '0) || ($signed(rd_data.value) < $signed(min_val_reg)))
            begin
                min_idx_reg <= rd_idx_reg;
                min_val_reg <= rd_data.value;
            end
            if (last_hit)
            begin
                last_key_reg <= rd_data.key;
                last_val_reg <= rd_data.value;
            end
        end
        // maximum, lowest index wins ties
        if ((state_reg == S_TOP) && rd_vld_reg)
        begin
            if ((rd_idx_reg == '0) || ($signed(rd_data.value) > $signed(max_val_reg)))
            begin
                max_val_reg <= rd_data.value;
                max_key_reg <= rd_data.key;
            end
        end
        // result register
        if ((state_reg == S_PUSH) && out_free)
        begin
            top_valid_reg   <= (count_reg != '0);
            top_key_reg     <= (count_reg != '0) ? max_key_reg : 32'd0;
            entry_count_reg <= 5'(count_reg);
            evicted_reg     <= ev_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign top_valid   = top_valid_reg;
    assign top_key     = top_key_reg;
    assign entry_count = entry_count_reg;
    assign evicted     = evicted_reg;

endmodule

/* src/kaemt_store.sv */
module kaemt_store
    import kaemt_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // Single write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/kaemt_scale.sv */
module kaemt_scale
    import kaemt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] value,
    input  logic [15:0] factor,
    output logic        done,
    output logic [63:0] result
);

    typedef enum logic [4:0] {
        SC_IDLE = 5'b00001,
        SC_LO   = 5'b00010,
        SC_HI   = 5'b00100,
        SC_SUM  = 5'b01000,
        SC_FIN  = 5'b10000
    } scale_state_t;

    scale_state_t state_reg, state_next;
    logic        done_reg;
    logic        neg_reg;
    logic [63:0] mv_reg;
    logic [15:0] mf_reg;
    logic [47:0] p0_reg;
    logic [47:0] p1_reg;
    logic [79:0] sum_reg;
    logic [63:0] result_reg;

    logic [31:0] mul_a;
    logic [47:0] prod;
    logic [63:0] m;
    logic [63:0] sat_val;

    // One 32x16 multiplier, shared by the low and high halves
    assign mul_a = (state_reg == SC_LO) ? mv_reg[31:0] : mv_reg[63:32];
    assign prod  = {16'd0, mul_a} * {32'd0, mf_reg};

    // Drop the Q8.8 fraction, clamp, restore sign
    assign m = sum_reg[71:8];
    always_comb
    begin
        if (sum_reg[79:72] != 8'd0)
        begin
            sat_val = neg_reg ? VAL_MIN : VAL_MAX;
        end
        else if (neg_reg)
        begin
            sat_val = m[63] ? VAL_MIN : (64'd0 - m);
        end
        else
        begin
            sat_val = m[63] ? VAL_MAX : m;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SC_IDLE: if (start) state_next = SC_LO;
            SC_LO:   state_next = SC_HI;
            SC_HI:   state_next = SC_SUM;
            SC_SUM:  state_next = SC_FIN;
            SC_FIN:  state_next = SC_IDLE;
            default: state_next = SC_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == SC_FIN);
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if ((state_reg == SC_IDLE) && start)
        begin
            neg_reg <= value[63] ^ factor[15];
            mv_reg  <= value[63] ? (64'd0 - value) : value;
            mf_reg  <= factor[15] ? (16'd0 - factor) : factor;
        end
        if (state_reg == SC_LO)
        begin
            p0_reg <= prod;
        end
        if (state_reg == SC_HI)
        begin
            p1_reg <= prod;
        end
        if (state_reg == SC_SUM)
        begin
            sum_reg <= {p1_reg, 32'd0} + {32'd0, p0_reg};
        end
        if (state_reg == SC_FIN)
        begin
            result_reg <= sat_val;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import kaemt_pkg::*;

    localparam int CAP          = 16;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_OPS   = 700;

    // One result as seen on the output channel
    typedef struct packed {
        logic        top_valid;
        logic [31:0] top_key;
        logic [4:0]  entry_count;
        logic        evicted;
    } result_t;

    localparam result_t EMPTY_RES = '0;

    // One row of the directed sequence; reps > 1 issues the row with key, key+1, ...
    typedef struct {
        logic [1:0]  op;
        logic [31:0] key;
        logic [63:0] amount;
        logic [15:0] factor;
        int          reps;
        bit          typed;
        result_t     res;
    } op_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  op = OP_QUERY;
    logic [31:0] key = '0;
    logic [63:0] amount = '0;
    logic [15:0] factor = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        top_valid;
    logic [31:0] top_key;
    logic [4:0]  entry_count;
    logic        evicted;

    // Mirror of the table contents
    logic [31:0]        mirror_key [CAP];
    logic signed [63:0] mirror_val [CAP];
    int                 mirror_count = 0;

    result_t pending_results [$];
    op_row_t directed_ops [$];
    logic [31:0] key_pool [20];
    int err_count = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int stall_left = 0;
    int stall_draw;
    int cycle_count = 0;

    keyed_accumulator_evict_min_table #(.CAPACITY(CAP)) u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .key         (key),
        .amount      (amount),
        .factor      (factor),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .top_valid   (top_valid),
        .top_key     (top_key),
        .entry_count (entry_count),
        .evicted     (evicted)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle cycles before a request or result; every fourth stretch of 32 runs flat out
    function automatic int draw_idle(int n);
        if ((n / 32) % 4 == 1)
        begin
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    // Signed add, clamped to the 64-bit range
    function automatic logic signed [63:0] clamp_sum(logic signed [63:0] a,
                                                     logic signed [63:0] b);
        logic signed [64:0] s;
        s = $signed({a[63], a}) + $signed({b[63], b});
        if (s[64] != s[63])
        begin
            return s[64] ? $signed(VAL_MIN) : $signed(VAL_MAX);
        end
        return s[63:0];
    endfunction

    // Q8.8 multiply: exact product, divide by 256 toward zero, clamp
    function automatic logic signed [63:0] scale_value(logic signed [63:0] v,
                                                       logic signed [15:0] f);
        logic signed [79:0] prod;
        logic [79:0] mag;
        logic [79:0] q;
        prod = v * f;
        mag = prod[79] ? -prod : prod;
        q = mag >> 8;
        if (prod[79])
        begin
            if (q >= 80'h8000_0000_0000_0000)
            begin
                return $signed(VAL_MIN);
            end
            return 64'(0) - q[63:0];
        end
        if (q > 80'h7FFF_FFFF_FFFF_FFFF)
        begin
            return $signed(VAL_MAX);
        end
        return q[63:0];
    endfunction

    // Apply one request to the mirror and return the result it should produce
    function automatic result_t apply_table_op(logic [1:0] op_c, logic [31:0] k,
                                               logic signed [63:0] amt,
                                               logic signed [15:0] fac);
        result_t r;
        int hit;
        int best;
        r = '0;
        hit = -1;
        for (int i = 0; i < mirror_count; i++)
        begin
            if (hit < 0 && mirror_key[i] == k)
            begin
                hit = i;
            end
        end
        case (op_c)
            OP_ADD:
            begin
                if (hit >= 0)
                begin
                    mirror_val[hit] = clamp_sum(mirror_val[hit], amt);
                end
                else if (mirror_count < CAP)
                begin
                    mirror_key[mirror_count] = k;
                    mirror_val[mirror_count] = amt;
                    mirror_count++;
                end
                else
                begin
                    // full: overwrite the first smallest entry
                    best = 0;
                    for (int i = 1; i < CAP; i++)
                    begin
                        if (mirror_val[i] < mirror_val[best])
                        begin
                            best = i;
                        end
                    end
                    mirror_key[best] = k;
                    mirror_val[best] = amt;
                    r.evicted = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (hit >= 0)
                begin
                    mirror_count--;
                    mirror_key[hit] = mirror_key[mirror_count];
                    mirror_val[hit] = mirror_val[mirror_count];
                end
            end
            OP_SCALE:
            begin
                if (hit >= 0)
                begin
                    mirror_val[hit] = scale_value(mirror_val[hit], fac);
                end
            end
            default:
            begin
            end
        endcase
        // first largest entry
        if (mirror_count > 0)
        begin
            best = 0;
            for (int i = 1; i < mirror_count; i++)
            begin
                if (mirror_val[i] > mirror_val[best])
                begin
                    best = i;
                end
            end
            r.top_valid = 1'b1;
            r.top_key = mirror_key[best];
        end
        r.entry_count = 5'(mirror_count);
        return r;
    endfunction

    // Present one request, wait for it to be taken, then queue its expected result
    task automatic send_request(input logic [1:0] r_op, input logic [31:0] r_key,
                                input logic [63:0] r_amount, input logic [15:0] r_factor,
                                input bit typed, input result_t typed_res);
        int gap;
        result_t exp_res;
        gap = draw_idle(requests_sent);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= r_op;
        key <= r_key;
        amount <= r_amount;
        factor <= r_factor;
        do
            @(posedge clk);
        while (in_stall);
        exp_res = apply_table_op(r_op, r_key, r_amount, r_factor);
        if (typed)
        begin
            exp_res = typed_res;
        end
        pending_results.push_back(exp_res);
        requests_sent++;
    endtask

    // Reset
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: check each taken result, then draw the stall before the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no request outstanding: top_key %h count %0d",
                         $time, top_key, entry_count);
                err_count++;
            end
            else
            begin
                automatic result_t exp_res = pending_results.pop_front();
                if (top_valid !== exp_res.top_valid)
                begin
                    $display("%0t: top_valid expected %b actual %b",
                             $time, exp_res.top_valid, top_valid);
                    err_count++;
                end
                if (top_key !== exp_res.top_key)
                begin
                    $display("%0t: top_key expected %h actual %h",
                             $time, exp_res.top_key, top_key);
                    err_count++;
                end
                if (entry_count !== exp_res.entry_count)
                begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, exp_res.entry_count, entry_count);
                    err_count++;
                end
                if (evicted !== exp_res.evicted)
                begin
                    $display("%0t: evicted expected %b actual %b",
                             $time, exp_res.evicted, evicted);
                    err_count++;
                end
            end
            results_seen++;
            stall_draw = draw_idle(results_seen);
            stall_left <= stall_draw;
            out_stall <= (stall_draw != 0);
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= (stall_left > 1);
        end
    end

    // Request side: directed sequence, then random traffic
    initial
    begin
        logic [1:0]         r_op;
        logic [31:0]        r_key;
        logic signed [63:0] r_amt;
        logic [15:0]        r_fac;
        int                 sel;
        int                 iv;

        // empty table, saturation, scale extremes, tie on the largest value
        directed_ops.push_back(op_row_t'{OP_QUERY, 32'd0, 64'd0, 16'h0000, 1, 1'b1, EMPTY_RES});
        directed_ops.push_back(op_row_t'{OP_REMOVE, 32'd5, 64'd0, 16'h0000, 1, 1'b1, EMPTY_RES});
        directed_ops.push_back(op_row_t'{OP_SCALE, 32'd5, 64'd0, 16'h0100, 1, 1'b1, EMPTY_RES});
        directed_ops.push_back(op_row_t'{OP_ADD, 32'hFFFF_FFFF, VAL_MAX, 16'h0000, 1, 1'b1,
                                         result_t'{1'b1, 32'hFFFF_FFFF, 5'd1, 1'b0}});
        directed_ops.push_back(op_row_t'{OP_ADD, 32'hFFFF_FFFF, 64'd1, 16'h0000, 1, 1'b1,
                                         result_t'{1'b1, 32'hFFFF_FFFF, 5'd1, 1'b0}});
        directed_ops.push_back(op_row_t'{OP_ADD, 32'd0, VAL_MIN, 16'h0000, 1, 1'b1,
                                         result_t'{1'b1, 32'hFFFF_FFFF, 5'd2, 1'b0}});
        directed_ops.push_back(op_row_t'{OP_ADD, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000,
                                         1, 1'b1, result_t'{1'b1, 32'hFFFF_FFFF, 5'd2, 1'b0}});
        directed_ops.push_back(op_row_t'{OP_SCALE, 32'hFFFF_FFFF, 64'd0, 16'h7FFF, 1, 1'b0,
                                         EMPTY_RES});
        directed_ops.push_back(op_row_t'{OP_SCALE, 32'd0, 64'd0, 16'h8000, 1, 1'b0, EMPTY_RES});
        directed_ops.push_back(op_row_t'{OP_SCALE, 32'd0, 64'd0, 16'hFF00, 1, 1'b0, EMPTY_RES});
        directed_ops.push_back(op_row_t'{OP_SCALE, 32'd0, 64'd0, 16'h0001, 1, 1'b0, EMPTY_RES});
        directed_ops.push_back(op_row_t'{OP_SCALE, 32'hFFFF_FFFF, 64'd0, 16'h0000, 1, 1'b0,
                                         EMPTY_RES});
        directed_ops.push_back(op_row_t'{OP_SCALE, 32'd12345, 64'd0, 16'h0200, 1, 1'b0,
                                         EMPTY_RES});
        directed_ops.push_back(op_row_t'{OP_QUERY, 32'd0, 64'd0, 16'h0000, 1, 1'b0, EMPTY_RES});
        directed_ops.push_back(op_row_t'{OP_REMOVE, 32'hFFFF_FFFF, 64'd0, 16'h0000, 1, 1'b0,
                                         EMPTY_RES});
        directed_ops.push_back(op_row_t'{OP_REMOVE, 32'd0, 64'd0, 16'h0000, 1, 1'b1, EMPTY_RES});
        // fill to capacity, hit a key, then evict twice
        directed_ops.push_back(op_row_t'{OP_ADD, 32'd100, 64'd10, 16'h0000, CAP, 1'b0,
                                         EMPTY_RES});
        directed_ops.push_back(op_row_t'{OP_ADD, 32'd100, -64'sd50, 16'h0000, 1, 1'b0,
                                         EMPTY_RES});
        directed_ops.push_back(op_row_t'{OP_ADD, 32'd200, 64'd7, 16'h0000, 1, 1'b0, EMPTY_RES});
        directed_ops.push_back(op_row_t'{OP_ADD, 32'd201, VAL_MIN, 16'h0000, 1, 1'b0,
                                         EMPTY_RES});
        directed_ops.push_back(op_row_t'{OP_REMOVE, 32'd107, 64'd0, 16'h0000, 1, 1'b0,
                                         EMPTY_RES});
        directed_ops.push_back(op_row_t'{OP_SCALE, 32'd101, 64'd0, 16'hFFFF, 1, 1'b0,
                                         EMPTY_RES});
        directed_ops.push_back(op_row_t'{OP_QUERY, 32'd0, 64'd0, 16'h0000, 1, 1'b0, EMPTY_RES});
        directed_ops.push_back(op_row_t'{OP_ADD, 32'd300, -64'sd3, 16'h0000, 1, 1'b0,
                                         EMPTY_RES});

        // small key pool so that adds, removes and scales often hit
        key_pool[0] = 32'd0;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 20; i++)
        begin
            key_pool[i] = $urandom;
        end

        wait (rst_n);
        @(posedge clk);

        foreach (directed_ops[i])
        begin
            for (int r = 0; r < directed_ops[i].reps; r++)
            begin
                send_request(directed_ops[i].op, directed_ops[i].key + r,
                             directed_ops[i].amount, directed_ops[i].factor,
                             directed_ops[i].typed, directed_ops[i].res);
            end
        end

        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            // alternate fill-heavy and drain-heavy stretches
            sel = $urandom_range(0, 99);
            if ((n / 100) % 2 == 0)
            begin
                r_op = (sel < 60) ? OP_ADD : (sel < 70) ? OP_REMOVE :
                       (sel < 85) ? OP_SCALE : OP_QUERY;
            end
            else
            begin
                r_op = (sel < 25) ? OP_ADD : (sel < 70) ? OP_REMOVE :
                       (sel < 85) ? OP_SCALE : OP_QUERY;
            end

            if ($urandom_range(0, 9) == 0)
            begin
                r_key = $urandom;
            end
            else
            begin
                r_key = key_pool[$urandom_range(0, 19)];
            end

            // amount: small, any magnitude, or near the limits
            sel = $urandom_range(0, 9);
            if (sel < 4)
            begin
                iv = $urandom_range(0, 2000);
                r_amt = 64'(iv - 1000);
            end
            else if (sel < 8)
            begin
                r_amt = $signed({$urandom, $urandom}) >>> $urandom_range(0, 63);
            end
            else if ($urandom_range(0, 1) == 1)
            begin
                r_amt = VAL_MAX - 64'($urandom_range(0, 3));
            end
            else
            begin
                r_amt = VAL_MIN + 64'($urandom_range(0, 3));
            end

            // factor: near +-1.0, any value, or an extreme
            sel = $urandom_range(0, 9);
            if (sel < 4)
            begin
                iv = 224 + int'($urandom_range(0, 64));
                if ($urandom_range(0, 1) == 1)
                begin
                    iv = -iv;
                end
                r_fac = 16'(iv);
            end
            else if (sel < 8)
            begin
                r_fac = 16'($urandom);
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0: r_fac = 16'h7FFF;
                    1: r_fac = 16'h8000;
                    2: r_fac = 16'h0000;
                    3: r_fac = 16'h0001;
                    4: r_fac = 16'hFFFF;
                    default: r_fac = 16'hFF00;
                endcase
            end

            send_request(r_op, r_key, r_amt, r_fac, 1'b0, EMPTY_RES);
        end

        // drain, then give the block time to show any stray result
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
